/* hw/rtl/keyed_record_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// keyed_record_table_unit_assert.svh
// assertion macros for the keyed record table, empty bodies in synthesis
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define KRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("keyed_record_table_unit: check failed");
// clocked check that also holds through reset
`define KRT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keyed_record_table_unit: check failed");
`else
`define KRT_ASSERT(lbl, clk, rst_n, prop)
`define KRT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/krt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// shared types and constants of the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_LIST   = 3'd1;
  localparam logic [2:0] MODE_LOOKUP = 3'd2;
  localparam logic [2:0] MODE_UPDATE = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] key;
    logic signed [31:0] phone;
    logic        [63:0] name_tag;
  } in_word_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] key_res;
    logic signed [31:0] phone_res;
    logic        [63:0] name_tag_res;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] phone;
    logic        [63:0] name_tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // request from the sequencer to the record memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // result word handed to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  // sequencer status
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

/* hw/rtl/krt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/krt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ctrl
// sequencer: scans, lists, inserts, updates and compacts the record memory
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  krt_pkg::in_word_t  in_word_i,
  input  logic               out_free_i,
  input  krt_pkg::rec_t      rdata_i,
  output krt_pkg::mem_req_t  mem_o,
  output krt_pkg::emit_t     emit_o,
  output krt_pkg::stat_t     stat_o
);

  import krt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_MISS   = 7'b0001000,
    S_HIT    = 7'b0010000,
    S_LIST   = 7'b0100000,
    S_SHIFT  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  in_word_t         cmd_q, cmd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  rec_t             rec_q, rec_d;
  logic             rd_last;
  logic             more;

  // read just returned is the top valid entry
  assign rd_last = ((CNT_W'(ridx_q) + CNT_W'(1)) == count_q);
  assign more    = (iss_q < count_q);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    iss_d   = iss_q;
    rv_d    = 1'b0;
    ridx_d  = ridx_q;
    pos_d   = pos_q;
    rec_d   = rec_q;
    mem_o   = '0;
    emit_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_word_i;
          iss_d = '0;
          if (in_word_i.mode inside {[MODE_INSERT:MODE_REMOVE]}) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (cmd_q.mode == MODE_INSERT) begin
          if (count_q == CNT_W'(CAPACITY)) begin
            if (out_free_i) begin
              emit_o.valid       = 1'b1;
              emit_o.word.status = ST_FULL;
              emit_o.word.last   = 1'b1;
              state_d            = S_IDLE;
            end
          end else if (count_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_SCAN;
          end
        end else if (count_q == '0) begin
          if (out_free_i) begin
            emit_o.valid       = 1'b1;
            emit_o.word.status = ST_EMPTY;
            emit_o.word.last   = 1'b1;
            state_d            = S_IDLE;
          end
        end else if (cmd_q.mode == MODE_LIST) begin
          state_d = S_LIST;
        end else begin
          state_d = S_SCAN;
        end
      end

      // pipelined key search, one entry per cycle
      S_SCAN: begin
        mem_o.re    = more;
        mem_o.raddr = iss_q[IDX_W-1:0];
        if (more) begin
          iss_d  = iss_q + CNT_W'(1);
          ridx_d = iss_q[IDX_W-1:0];
        end
        rv_d = more;
        if (rv_q) begin
          if (rdata_i.key == cmd_q.key) begin
            rec_d   = rdata_i;
            pos_d   = ridx_q;
            state_d = S_HIT;
          end else if (rd_last) begin
            state_d = S_MISS;
          end
        end
      end

      S_MISS: begin
        if (out_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.word.last = 1'b1;
          state_d          = S_IDLE;
          if (cmd_q.mode == MODE_INSERT) begin
            mem_o.we                 = 1'b1;
            mem_o.waddr              = count_q[IDX_W-1:0];
            mem_o.wdata.key          = cmd_q.key;
            mem_o.wdata.phone        = cmd_q.phone;
            mem_o.wdata.name_tag     = cmd_q.name_tag;
            emit_o.word.status       = ST_OK;
            emit_o.word.key_res      = cmd_q.key;
            emit_o.word.phone_res    = cmd_q.phone;
            emit_o.word.name_tag_res = cmd_q.name_tag;
            count_d                  = count_q + CNT_W'(1);
          end else begin
            emit_o.word.status = ST_NOTFOUND;
          end
        end
      end

      S_HIT: begin
        if (out_free_i) begin
          emit_o.valid             = 1'b1;
          emit_o.word.last         = 1'b1;
          emit_o.word.status       = ST_OK;
          emit_o.word.key_res      = rec_q.key;
          emit_o.word.phone_res    = rec_q.phone;
          emit_o.word.name_tag_res = rec_q.name_tag;
          state_d                  = S_IDLE;
          case (cmd_q.mode)
            MODE_INSERT: begin
              emit_o.word = '0;
              emit_o.word.status = ST_DUP;
              emit_o.word.last   = 1'b1;
            end
            MODE_UPDATE: begin
              mem_o.we                 = 1'b1;
              mem_o.waddr              = pos_q;
              mem_o.wdata.key          = rec_q.key;
              mem_o.wdata.phone        = cmd_q.phone;
              mem_o.wdata.name_tag     = cmd_q.name_tag;
              emit_o.word.phone_res    = cmd_q.phone;
              emit_o.word.name_tag_res = cmd_q.name_tag;
            end
            MODE_REMOVE: begin
              iss_d   = CNT_W'(pos_q) + CNT_W'(1);
              state_d = S_SHIFT;
            end
            default: begin
            end
          endcase
        end
      end

      // one read in flight, held in the ram output until emitted
      S_LIST: begin
        mem_o.re    = !rv_q && more;
        mem_o.raddr = iss_q[IDX_W-1:0];
        if (mem_o.re) begin
          iss_d  = iss_q + CNT_W'(1);
          ridx_d = iss_q[IDX_W-1:0];
        end
        rv_d = mem_o.re || (rv_q && !out_free_i);
        if (rv_q && out_free_i) begin
          emit_o.valid             = 1'b1;
          emit_o.word.status       = ST_OK;
          emit_o.word.key_res      = rdata_i.key;
          emit_o.word.phone_res    = rdata_i.phone;
          emit_o.word.name_tag_res = rdata_i.name_tag;
          emit_o.word.last         = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end

      // compaction: read entry i, write it to i-1 in the following cycle
      S_SHIFT: begin
        mem_o.re    = more;
        mem_o.raddr = iss_q[IDX_W-1:0];
        if (more) begin
          iss_d  = iss_q + CNT_W'(1);
          ridx_d = iss_q[IDX_W-1:0];
        end
        rv_d = more;
        if (rv_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = ridx_q - IDX_W'(1);
          mem_o.wdata = rdata_i;
        end
        if (!more && !rv_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    iss_q  <= iss_d;
    ridx_q <= ridx_d;
    pos_q  <= pos_d;
    rec_q  <= rec_d;
  end

  assign stat_o.idle  = (state_q == S_IDLE);
  assign stat_o.count = count_q;

endmodule

/* hw/rtl/keyed_record_table_unit.sv */
`timescale 1ns / 1ps
`include "keyed_record_table_unit_assert.svh"
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// table of up to CAPACITY records keyed by a unique signed identifier
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_ready_o carries one command word: mode,
//   key, phone and name tag. modes 5 to 7 are taken and dropped silently.
//   output channel out_valid_o / out_ready_i carries result words; list
//   gives one word per stored record (one empty-status word if there is none),
//   every other mode gives one word, and the final word of a command has last set.
// timing:
//   one command at a time. a command passes through the idle and decide
//   states for dispatch, then the key search reads one memory entry per
//   cycle through the single read port. remove adds a compaction pass of
//   one entry per cycle over the records behind the hit. list reads one
//   record, then emits it, before it reads the next, and holds while the
//   receiver does not take the word.
// stalls:
//   results sit in an output register; a new command is taken while the
//   last result still waits. the sequencer holds when it needs to emit and
//   the register is full, so a stalled receiver stalls the block.
// reset:
//   clears the record count and the sequencer; memory contents are left
//   as they are and never read before being written. no clearing pass.
// ----------------------------------------------------------------------------
module keyed_record_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  krt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output krt_pkg::out_word_t out_word_o
);

  import krt_pkg::*;

  mem_req_t         mem_req;
  emit_t            emit;
  stat_t            stat;
  logic [REC_W-1:0] rdata_raw;
  logic             out_free;
  logic             out_valid_q;
  out_word_t        out_word_q;

  // output register can take a word when empty or draining this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // ready only while the sequencer waits for a command
  assign in_ready_o = stat.idle;

  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .out_free_i (out_free),
    .rdata_i    (rec_t'(rdata_raw)),
    .mem_o      (mem_req),
    .emit_o     (emit),
    .stat_o     (stat)
  );

  // record store, one read and one write port, registered read
  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_word_q <= emit.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // sequencer never pushes into an occupied, stalled output register
  `KRT_ASSERT(a_emit_room, clk_i, rst_ni, emit.valid |-> (!out_valid_q || out_ready_i))
  // error results always close their command
  `KRT_ASSERT(a_err_last, clk_i, rst_ni, (emit.valid && emit.word.status != ST_OK) |-> emit.word.last)
  // no result is produced while waiting for a command
  `KRT_ASSERT(a_idle_quiet, clk_i, rst_ni, in_ready_o |-> !emit.valid)
  // record count stays within capacity, unknown only before the first reset edge
  `KRT_ASSERT_ALWAYS(a_count_cap, clk_i, !rst_ni || (stat.count <= CNT_W'(CAPACITY)))

endmodule
